/* design/cpu_load_from_tick_counters_defines.svh */
// ----------------------------------------------------------------------------
// cpu load assertion macros
// shared assertion forms for the cpu load checker
// ----------------------------------------------------------------------------
`ifndef CPU_LOAD_FROM_TICK_COUNTERS_DEFINES_SVH
`define CPU_LOAD_FROM_TICK_COUNTERS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CLT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/clt_pkg.sv */
// ----------------------------------------------------------------------------
// cpu load package
// widths, constants, state and command types shared by the cpu load block
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

    localparam int TICK_W     = 64;
    localparam int HALF_W     = TICK_W / 2;
    localparam int SHARE_W    = 32;
    localparam int SCALE_W    = 20;
    localparam int PROD_W     = SCALE_W + HALF_W;
    localparam int DIV_STEPS  = TICK_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    // reset value of the scale register
    localparam logic [SCALE_W-1:0] LOAD_SCALE_RESET = 20'd100000;

    // register index of the scale register
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_SCALE = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_PART,
        S_SUM_TOTAL,
        S_CHECK,
        S_MUL_LO,
        S_MUL_HI,
        S_PROD,
        S_DIV,
        S_STORE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        LANE_USER,
        LANE_KERNEL,
        LANE_IDLE
    } lane_t;

    typedef struct packed {
        logic  load_sample;
        logic  sum_part;
        logic  sum_total;
        logic  check;
        logic  mul_lo;
        logic  mul_hi;
        logic  prod;
        logic  div_step;
        logic  store;
        logic  out_load;
        lane_t lane;
    } ctrl_cmd_t;

    typedef struct packed {
        logic total_zero;
        logic div_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

/* design/clt_sample_if.sv */
// ----------------------------------------------------------------------------
// cpu load sample channel
// valid/ready channel carrying one sample of the three tick counters
// ----------------------------------------------------------------------------
`default_nettype none

interface clt_sample_if;
    logic                        valid;
    logic                        ready;
    logic [clt_pkg::TICK_W-1:0]  user_ticks;
    logic [clt_pkg::TICK_W-1:0]  kernel_ticks;
    logic [clt_pkg::TICK_W-1:0]  idle_ticks;

    modport source (output valid, output user_ticks, output kernel_ticks,
                    output idle_ticks, input ready);
    modport sink   (input valid, input user_ticks, input kernel_ticks,
                    input idle_ticks, output ready);
endinterface

`default_nettype wire

/* design/clt_share_if.sv */
// ----------------------------------------------------------------------------
// cpu load share channel
// valid/ready channel carrying the three scaled shares and the stall flag
// ----------------------------------------------------------------------------
`default_nettype none

interface clt_share_if;
    logic                         valid;
    logic                         ready;
    logic [clt_pkg::SHARE_W-1:0]  user_share;
    logic [clt_pkg::SHARE_W-1:0]  kernel_share;
    logic [clt_pkg::SHARE_W-1:0]  idle_share;
    logic                         no_progress;

    modport source (output valid, output user_share, output kernel_share,
                    output idle_share, output no_progress, input ready);
    modport sink   (input valid, input user_share, input kernel_share,
                    input idle_share, input no_progress, output ready);
endinterface

`default_nettype wire

/* design/clt_regs.sv */
// ----------------------------------------------------------------------------
// cpu load configuration registers
// apb-style register file holding the load scale
// ----------------------------------------------------------------------------
`default_nettype none

module clt_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [clt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [clt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [clt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic      [clt_pkg::SCALE_W-1:0]      load_scale
);

    logic [clt_pkg::SCALE_W-1:0]   scale_reg;
    logic [clt_pkg::SCALE_W-1:0]   scale_next;
    logic [clt_pkg::CFG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    // word index, byte lanes ignored
    assign reg_idx = paddr[clt_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        scale_next = scale_reg;
        if (wr_en && (reg_idx == clt_pkg::REG_LOAD_SCALE))
        begin
            scale_next = pwdata[clt_pkg::SCALE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= clt_pkg::LOAD_SCALE_RESET;
        end
        else
        begin
            scale_reg <= scale_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == clt_pkg::REG_LOAD_SCALE)
        begin
            prdata = {{(clt_pkg::CFG_DATA_W - clt_pkg::SCALE_W){1'b0}}, scale_reg};
        end
    end

    assign load_scale = scale_reg;

endmodule

`default_nettype wire

/* design/clt_ctrl.sv */
// ----------------------------------------------------------------------------
// cpu load controller
// sequences difference, total, per-lane multiply and divide, and output load
// ----------------------------------------------------------------------------
`default_nettype none

module clt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire clt_pkg::ctrl_sts_t  sts,
    output clt_pkg::ctrl_cmd_t       cmd
);

    clt_pkg::state_t state_reg;
    clt_pkg::state_t state_next;
    clt_pkg::lane_t  lane_reg;
    clt_pkg::lane_t  lane_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clt_pkg::S_IDLE;
            lane_reg  <= clt_pkg::LANE_USER;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        cmd        = '0;
        cmd.lane   = lane_reg;
        in_ready   = 1'b0;

        unique case (state_reg)
            clt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = clt_pkg::S_SUM_PART;
                end
            end
            clt_pkg::S_SUM_PART:
            begin
                cmd.sum_part = 1'b1;
                state_next   = clt_pkg::S_SUM_TOTAL;
            end
            clt_pkg::S_SUM_TOTAL:
            begin
                cmd.sum_total = 1'b1;
                state_next    = clt_pkg::S_CHECK;
            end
            clt_pkg::S_CHECK:
            begin
                cmd.check = 1'b1;
                lane_next = clt_pkg::LANE_USER;
                if (sts.total_zero)
                begin
                    state_next = clt_pkg::S_DONE;
                end
                else
                begin
                    state_next = clt_pkg::S_MUL_LO;
                end
            end
            clt_pkg::S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = clt_pkg::S_MUL_HI;
            end
            clt_pkg::S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = clt_pkg::S_PROD;
            end
            clt_pkg::S_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = clt_pkg::S_DIV;
            end
            clt_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = clt_pkg::S_STORE;
                end
            end
            clt_pkg::S_STORE:
            begin
                cmd.store = 1'b1;
                unique case (lane_reg)
                    clt_pkg::LANE_USER:
                    begin
                        lane_next  = clt_pkg::LANE_KERNEL;
                        state_next = clt_pkg::S_MUL_LO;
                    end
                    clt_pkg::LANE_KERNEL:
                    begin
                        lane_next  = clt_pkg::LANE_IDLE;
                        state_next = clt_pkg::S_MUL_LO;
                    end
                    default:
                    begin
                        lane_next  = clt_pkg::LANE_USER;
                        state_next = clt_pkg::S_DONE;
                    end
                endcase
            end
            clt_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = clt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = clt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/clt_dpath.sv */
// ----------------------------------------------------------------------------
// cpu load datapath
// tick differences, total, split 64-bit product and radix-2 restoring divider
// ----------------------------------------------------------------------------
`default_nettype none

module clt_dpath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire clt_pkg::ctrl_cmd_t              cmd,
    output clt_pkg::ctrl_sts_t                   sts,
    input  wire logic [clt_pkg::SCALE_W-1:0]     load_scale,
    input  wire logic [clt_pkg::TICK_W-1:0]      user_ticks,
    input  wire logic [clt_pkg::TICK_W-1:0]      kernel_ticks,
    input  wire logic [clt_pkg::TICK_W-1:0]      idle_ticks,
    input  wire logic                            share_ready,
    output logic                                 share_valid,
    output logic      [clt_pkg::SHARE_W-1:0]     user_share,
    output logic      [clt_pkg::SHARE_W-1:0]     kernel_share,
    output logic      [clt_pkg::SHARE_W-1:0]     idle_share,
    output logic                                 no_progress
);

    localparam int TW = clt_pkg::TICK_W;
    localparam int HW = clt_pkg::HALF_W;
    localparam int PW = clt_pkg::PROD_W;
    localparam int SW = clt_pkg::SHARE_W;

    // previous sample
    logic [TW-1:0] last_u_reg, last_k_reg, last_i_reg;

    // working values
    logic [TW-1:0] diff_u_reg, diff_k_reg, diff_i_reg;
    logic [TW-1:0] sum_reg;
    logic [PW-1:0] plo_reg;
    logic [HW-1:0] phi_reg;
    logic [TW-1:0] quo_reg;
    logic [TW-1:0] rem_reg;
    logic [clt_pkg::CNT_W-1:0] cnt_reg;
    logic [SW-1:0] shr_u_reg, shr_k_reg, shr_i_reg;
    logic          np_reg;

    // output stage
    logic          out_valid_reg;
    logic [SW-1:0] out_u_reg, out_k_reg, out_i_reg;
    logic          out_np_reg;

    logic [TW-1:0] diff_sel;
    logic [HW-1:0] mul_a;
    logic [PW-1:0] mul_res;
    logic [TW-1:0] prod_sum;
    logic [TW:0]   rem_shift;
    logic [TW:0]   rem_try;
    logic          quo_bit;

    always_comb
    begin
        unique case (cmd.lane)
            clt_pkg::LANE_USER:   diff_sel = diff_u_reg;
            clt_pkg::LANE_KERNEL: diff_sel = diff_k_reg;
            default:              diff_sel = diff_i_reg;
        endcase
    end

    // one 20x32 multiplier, low half then high half of the difference
    assign mul_a    = cmd.mul_hi ? diff_sel[TW-1:HW] : diff_sel[HW-1:0];
    assign mul_res  = {{HW{1'b0}}, load_scale} * {{clt_pkg::SCALE_W{1'b0}}, mul_a};
    // product modulo 2^64
    assign prod_sum = {phi_reg, {HW{1'b0}}} + {{(TW - PW){1'b0}}, plo_reg};

    // restoring step, dividend bits shift out of the quotient register
    assign rem_shift = {rem_reg, quo_reg[TW-1]};
    assign rem_try   = rem_shift - {1'b0, sum_reg};
    assign quo_bit   = !rem_try[TW];

    assign sts.total_zero = (sum_reg == '0);
    assign sts.div_last   = (cnt_reg == clt_pkg::CNT_W'(clt_pkg::DIV_STEPS - 1));
    assign sts.out_free   = !out_valid_reg || share_ready;

    // control and state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_u_reg    <= '0;
            last_k_reg    <= '0;
            last_i_reg    <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cmd.load_sample)
            begin
                last_u_reg <= user_ticks;
                last_k_reg <= kernel_ticks;
                last_i_reg <= idle_ticks;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (share_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.prod)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            diff_u_reg <= user_ticks - last_u_reg;
            diff_k_reg <= kernel_ticks - last_k_reg;
            diff_i_reg <= idle_ticks - last_i_reg;
        end
        if (cmd.sum_part)
        begin
            sum_reg <= diff_u_reg + diff_k_reg;
        end
        else if (cmd.sum_total)
        begin
            sum_reg <= sum_reg + diff_i_reg;
        end
        if (cmd.check)
        begin
            shr_u_reg <= '0;
            shr_k_reg <= '0;
            shr_i_reg <= '0;
            np_reg    <= sts.total_zero;
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= mul_res;
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= mul_res[HW-1:0];
        end
        if (cmd.prod)
        begin
            quo_reg <= prod_sum;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[TW-2:0], quo_bit};
            rem_reg <= quo_bit ? rem_try[TW-1:0] : rem_shift[TW-1:0];
        end
        if (cmd.store)
        begin
            unique case (cmd.lane)
                clt_pkg::LANE_USER:   shr_u_reg <= quo_reg[SW-1:0];
                clt_pkg::LANE_KERNEL: shr_k_reg <= quo_reg[SW-1:0];
                default:              shr_i_reg <= quo_reg[SW-1:0];
            endcase
        end
        if (cmd.out_load)
        begin
            out_u_reg  <= shr_u_reg;
            out_k_reg  <= shr_k_reg;
            out_i_reg  <= shr_i_reg;
            out_np_reg <= np_reg;
        end
    end

    assign share_valid  = out_valid_reg;
    assign user_share   = out_u_reg;
    assign kernel_share = out_k_reg;
    assign idle_share   = out_i_reg;
    assign no_progress  = out_np_reg;

endmodule

`default_nettype wire

/* design/cpu_load_from_tick_counters.sv */
// ----------------------------------------------------------------------------
// cpu load from tick counters
// scaled user, kernel and idle shares from two successive counter samples
// ----------------------------------------------------------------------------
// usage
//   sample channel: one transfer carries user, kernel and idle tick counters
//   share channel: one transfer per sample with the three scaled shares and
//     no_progress, set when the tick total did not move (shares then zero)
//   apb port: register 0 at byte address 0 is the 20-bit load scale
//   sequence: differences, total and zero check, then for each lane the low
//     and high multiply, product, divide and store; a zero total skips them
//   a new sample is taken only once the last one's shares have been loaded,
//     and the shared 64-step restoring divider runs once per share
//   the output register holds a finished result while the next sample is
//     taken; with the receiver stalled the controller waits in its done state
//   reset clears the stored sample to zero, so the first sample is measured
//     against zeros; the scale returns to 100000
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_load_from_tick_counters (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    clt_sample_if.sink                            sample,
    clt_share_if.source                           share,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [clt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [clt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [clt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready
);

    clt_pkg::ctrl_cmd_t           cmd;
    clt_pkg::ctrl_sts_t           sts;
    logic [clt_pkg::SCALE_W-1:0]  load_scale;
    logic                         in_ready;

    // configuration register file
    clt_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .load_scale (load_scale)
    );

    // sequencer: one sample in flight, three shares through one divider
    clt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign sample.ready = in_ready;

    // differences, product, division and output register
    clt_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .load_scale   (load_scale),
        .user_ticks   (sample.user_ticks),
        .kernel_ticks (sample.kernel_ticks),
        .idle_ticks   (sample.idle_ticks),
        .share_ready  (share.ready),
        .share_valid  (share.valid),
        .user_share   (share.user_share),
        .kernel_share (share.kernel_share),
        .idle_share   (share.idle_share),
        .no_progress  (share.no_progress)
    );

endmodule

`default_nettype wire

/* design/clt_checker.sv */
// ----------------------------------------------------------------------------
// cpu load port checker
// port-level checks on the sample and share channels
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu_load_from_tick_counters_defines.svh"

module clt_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [clt_pkg::SHARE_W-1:0]  user_share,
    input wire logic [clt_pkg::SHARE_W-1:0]  kernel_share,
    input wire logic [clt_pkg::SHARE_W-1:0]  idle_share,
    input wire logic                         no_progress
);

    // a stalled result keeps its valid and payload
    `CLT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(user_share) && $stable(kernel_share) && $stable(idle_share) && $stable(no_progress), "share changed while stalled")

    // a stalled tick total forces all shares to zero
    `CLT_ASSERT_NOW(a_np_zero, clk, rst_n, out_valid && no_progress, (user_share == '0) && (kernel_share == '0) && (idle_share == '0), "non-zero share with no progress")

    // one sample at a time: busy straight after a transfer
    `CLT_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "sample taken while busy")

endmodule

bind cpu_load_from_tick_counters clt_checker u_clt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .out_valid    (share.valid),
    .out_ready    (share.ready),
    .user_share   (share.user_share),
    .kernel_share (share.kernel_share),
    .idle_share   (share.idle_share),
    .no_progress  (share.no_progress)
);

`default_nettype wire
